### rtl/core/bfmc_pkg.sv
// Package for the box filter mip chain unit: payload types, level limits, helpers.
// No dependencies; used by every file under rtl/core.
`timescale 1ns / 1ps
package bfmc_pkg;

    localparam int MaxDim     = 4096;
    localparam int LevelCount = 13;
    localparam int LvlW       = 4;
    localparam int DimW       = 13;
    localparam int PosW       = 12;
    localparam int SumW       = 33;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [31:0] red_in;
        logic signed [31:0] green_in;
        logic signed [31:0] blue_in;
        logic signed [31:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [LvlW-1:0]    mip_level;
        logic [PosW-1:0]    pixel_x;
        logic [PosW-1:0]    pixel_y;
        logic signed [31:0] red_out;
        logic signed [31:0] green_out;
        logic signed [31:0] blue_out;
        logic signed [31:0] alpha_out;
        logic               last_of_run;
    } pix_out_t;

    typedef logic signed [31:0] chan4_t [4];
    typedef logic signed [SumW-1:0] sum4_t [4];

    // Token that travels down the cell row: one pixel bound for one level.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
    } tok_t;

    // Per-level geometry computed from the configured dimensions.
    typedef struct packed {
        logic            active;
        logic            has_next;
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
        logic [PosW:0]   off;
    } geom_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
        logic [DimW-1:0] r;
        r = v;
        if (v == '0) r = DimW'(1);
        else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
        return r;
    endfunction

    function automatic logic [DimW-1:0] half_dim(input logic [DimW-1:0] v);
        return (v > DimW'(1)) ? (v >> 1) : DimW'(1);
    endfunction

    // floor(sum / 4) of a 34-bit exact sum, fits 32 bits
    function automatic logic signed [31:0] quarter(input logic signed [33:0] s);
        return s[33:2];
    endfunction

endpackage

### rtl/core/box_filter_mip_chain_unit.sv
// Box filter mip chain unit: a row of level cells, one per mip level.
// Level 0 echo is queued in the cycle of accept; each lower level adds one cell register.
// Throughput: one request per cycle unless the previous request is still walking
// down the cells, the output queue holds more than 34 results or a config write is
// offered; sustained rate is set by the single output port, about 4/3 results
// per request. Reset clears counters, queue and dimensions (1x1); row memories
// are undefined until written. Depends on bfmc_pkg and bfmc_cell.
`timescale 1ns / 1ps
module box_filter_mip_chain_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bfmc_pkg::pix_in_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bfmc_pkg::pix_out_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [12:0]           cfg_data
);

    localparam int NL = bfmc_pkg::LevelCount;
    localparam int QD = 64;
    localparam int QW = 6;

    logic [bfmc_pkg::DimW-1:0] width_reg, height_reg;
    logic                      restart;
    bfmc_pkg::geom_t           geom [NL];
    bfmc_pkg::tok_t            tok [NL+1];
    logic                      ev [NL];
    bfmc_pkg::pix_out_t        ed [NL];

    // Output queue: at most one cell emits per cycle, since a new request is
    // held until the previous request's token has left the cell row.
    bfmc_pkg::pix_out_t        q_mem [QD];
    logic [QW-1:0]             wp_reg, rp_reg;
    logic [QW:0]               cnt_reg;
    logic                      busy;
    logic                      chain_busy;
    logic                      push, pop;
    bfmc_pkg::pix_out_t        push_data;
    logic                      outv_reg;
    bfmc_pkg::pix_out_t        outd_reg;

    // Derive level geometry from the clamped dimensions.
    always_comb
    begin
        logic [bfmc_pkg::DimW-1:0] w, h;
        logic [bfmc_pkg::PosW:0]   off;
        logic                      alive;
        w = bfmc_pkg::clamp_dim(width_reg);
        h = bfmc_pkg::clamp_dim(height_reg);
        off = '0;
        alive = 1'b1;
        for (int l = 0; l < NL; l++)
        begin
            geom[l].active   = alive;
            geom[l].w        = w;
            geom[l].h        = h;
            geom[l].off      = off;
            geom[l].has_next = alive && !(w == 13'd1 && h == 13'd1);
            alive = geom[l].has_next;
            w = bfmc_pkg::half_dim(w);
            h = bfmc_pkg::half_dim(h);
            off = off + w[bfmc_pkg::PosW:0];
        end
    end

    assign cfg_ready = !busy;
    assign restart   = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
        end
        else if (restart)
        begin
            unique case (cfg_index)
                bfmc_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bfmc_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Keep room for a full burst of results; hold a request while the previous
    // one still travels down the cells, and while a config write is offered.
    assign in_stall = cfg_valid || (cnt_reg > 7'(QD - 2*NL - 4)) || chain_busy;

    assign tok[0].valid = in_valid && !in_stall;
    assign tok[0].c0 = in_data.red_in;
    assign tok[0].c1 = in_data.green_in;
    assign tok[0].c2 = in_data.blue_in;
    assign tok[0].c3 = in_data.alpha_in;

    for (genvar l = 0; l < NL; l++)
    begin : g_cell
        bfmc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .restart    (restart),
            .geom       (geom[l]),
            .level      (bfmc_pkg::LvlW'(l)),
            .tok_in     (tok[l]),
            .tok_out    (tok[l+1]),
            .emit_valid (ev[l]),
            .emit_data  (ed[l])
        );
    end

    always_comb
    begin
        push = 1'b0;
        push_data = ed[0];
        for (int l = 0; l < NL; l++)
        begin
            if (ev[l] && geom[l].active)
            begin
                push = 1'b1;
                push_data = ed[l];
            end
        end
    end

    assign pop = (cnt_reg != '0) && (!outv_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wp_reg] <= push_data;
        if (pop)  outd_reg <= q_mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + QW'(0) + {6'd0, push} - {6'd0, pop};
            if (pop) outv_reg <= 1'b1;
            else if (!out_stall) outv_reg <= 1'b0;
        end
    end

    // Block is busy while any token is in flight or results are queued.
    always_comb
    begin
        chain_busy = 1'b0;
        for (int l = 1; l <= NL; l++) chain_busy = chain_busy || tok[l].valid;
        busy = (cnt_reg != '0) || outv_reg || chain_busy;
    end

    assign out_valid = outv_reg;
    assign out_data  = outd_reg;

endmodule

### rtl/core/bfmc_cell.sv
// One level cell of the mip chain: position counters, left hold, pair row memory.
// Depends on bfmc_pkg.
`timescale 1ns / 1ps
module bfmc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  bfmc_pkg::geom_t               geom,
    input  logic [bfmc_pkg::LvlW-1:0]     level,
    input  bfmc_pkg::tok_t                tok_in,
    output bfmc_pkg::tok_t                tok_out,
    output logic                          emit_valid,
    output bfmc_pkg::pix_out_t            emit_data
);

    logic [bfmc_pkg::PosW-1:0] x_reg, x_next, y_reg, y_next;
    logic [bfmc_pkg::PosW:0]   x_inc, y_inc;
    logic signed [31:0]        hold_reg [4];
    logic signed [bfmc_pkg::SumW-1:0] row_mem [4][bfmc_pkg::MaxDim/2];
    logic [bfmc_pkg::PosW-2:0] col;
    logic signed [31:0]        v [4];
    logic signed [bfmc_pkg::SumW-1:0] pair [4];
    logic signed [bfmc_pkg::SumW-1:0] rd [4];
    logic                      fwd, wr_hold, wr_row, use_row;
    logic                      st_valid_reg;
    logic                      st_row_reg;
    logic signed [bfmc_pkg::SumW-1:0] st_pair_reg [4];

    assign v[0] = tok_in.c0;
    assign v[1] = tok_in.c1;
    assign v[2] = tok_in.c2;
    assign v[3] = tok_in.c3;
    assign col  = x_reg[bfmc_pkg::PosW-1:1];

    always_comb
    begin
        x_inc  = {1'b0, x_reg} + 1'b1;
        y_inc  = {1'b0, y_reg} + 1'b1;
        x_next = x_inc[bfmc_pkg::PosW-1:0];
        y_next = y_reg;
        if (x_inc >= geom.w)
        begin
            x_next = '0;
            y_next = (y_inc >= geom.h) ? '0 : y_inc[bfmc_pkg::PosW-1:0];
        end
        wr_hold = 1'b0;
        wr_row  = 1'b0;
        use_row = 1'b0;
        fwd     = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            pair[c] = (geom.w == bfmc_pkg::DimW'(1))
                    ? (bfmc_pkg::SumW'(v[c]) + bfmc_pkg::SumW'(v[c]))
                    : (bfmc_pkg::SumW'(hold_reg[c]) + bfmc_pkg::SumW'(v[c]));
        end
        if (tok_in.valid && geom.has_next)
        begin
            if (geom.w != bfmc_pkg::DimW'(1) && !x_reg[0]) wr_hold = 1'b1;
            else if (geom.h == bfmc_pkg::DimW'(1)) fwd = 1'b1;
            else if (!y_reg[0]) wr_row = 1'b1;
            else use_row = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            st_valid_reg <= 1'b0;
            st_row_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (tok_in.valid)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            st_valid_reg <= (fwd || use_row) && !restart;
            st_row_reg   <= use_row;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (wr_hold) hold_reg[c] <= v[c];
            st_pair_reg[c] <= pair[c];
        end
    end

    // Pair row memory: one write and one read per cycle, registered read.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (wr_row) row_mem[c][col] <= pair[c];
            rd[c] <= row_mem[c][col];
        end
    end

    always_comb
    begin
        logic signed [33:0] s [4];
        for (int c = 0; c < 4; c++)
        begin
            s[c] = st_row_reg ? (34'(rd[c]) + 34'(st_pair_reg[c]))
                              : (34'(st_pair_reg[c]) + 34'(st_pair_reg[c]));
        end
        tok_out.valid = st_valid_reg;
        tok_out.c0 = bfmc_pkg::quarter(s[0]);
        tok_out.c1 = bfmc_pkg::quarter(s[1]);
        tok_out.c2 = bfmc_pkg::quarter(s[2]);
        tok_out.c3 = bfmc_pkg::quarter(s[3]);
    end

    assign emit_valid = tok_in.valid;
    always_comb
    begin
        emit_data.mip_level   = level;
        emit_data.pixel_x     = x_reg;
        emit_data.pixel_y     = y_reg;
        emit_data.red_out     = tok_in.c0;
        emit_data.green_out   = tok_in.c1;
        emit_data.blue_out    = tok_in.c2;
        emit_data.alpha_out   = tok_in.c3;
        emit_data.last_of_run = !(geom.has_next && (fwd || use_row));
    end

endmodule

### rtl/core/bfmc_checker.sv
// Port-level checker for the box filter mip chain unit, bound to the top level.
// Depends on bfmc_pkg.
`timescale 1ns / 1ps
module bfmc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bfmc_pkg::pix_out_t out_data,
    input logic               cfg_valid,
    input logic               cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.mip_level < 4'd13) else $error("level range");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(in_valid && !in_stall)) else $error("cfg while busy");
endmodule

bind box_filter_mip_chain_unit bfmc_checker u_bfmc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

### verif/box_filter_mip_chain_checker.sv
// Checker for the box filter mip chain unit: watches the config, input and
// output channels, predicts every output pixel and compares. Depends on bfmc_pkg.
`timescale 1ns / 1ps
module box_filter_mip_chain_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  bfmc_pkg::pix_in_t    in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  bfmc_pkg::pix_out_t   out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    logic [bfmc_pkg::DimW-1:0] width_reg;
    logic [bfmc_pkg::DimW-1:0] height_reg;
    int                 level_w [bfmc_pkg::LevelCount];
    int                 level_h [bfmc_pkg::LevelCount];
    int                 level_off [bfmc_pkg::LevelCount];
    int                 num_levels;
    int                 col_pos [bfmc_pkg::LevelCount];
    int                 row_pos [bfmc_pkg::LevelCount];
    logic signed [31:0] left_hold [bfmc_pkg::LevelCount][4];
    logic signed [32:0] row_pair_sums [4][bfmc_pkg::MaxDim];
    bfmc_pkg::pix_out_t expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic int clip_dim(logic [bfmc_pkg::DimW-1:0] v);
        if (v == 0)
            return 1;
        if (v > bfmc_pkg::MaxDim)
            return bfmc_pkg::MaxDim;
        return v;
    endfunction

    // Rebuild the level sizes and restart the image.
    function automatic void rebuild_levels();
        int w;
        int h;
        int off;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        off = 0;
        num_levels = 0;
        for (int l = 0; l < bfmc_pkg::LevelCount; l++)
        begin
            col_pos[l] = 0;
            row_pos[l] = 0;
        end
        for (int l = 0; l < bfmc_pkg::LevelCount; l++)
        begin
            level_w[l] = w;
            level_h[l] = h;
            level_off[l] = off;
            num_levels = l + 1;
            if (w == 1 && h == 1)
                break;
            w = (w > 1) ? w / 2 : 1;
            h = (h > 1) ? h / 2 : 1;
            off += w;
        end
    endfunction

    // Echo the pixel at level 0, then queue each lower-level pixel it completes.
    function automatic void predict_pixels(bfmc_pkg::pix_in_t p);
        logic signed [31:0] v [4];
        logic signed [32:0] pair [4];
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [33:0] total;
        bfmc_pkg::pix_out_t r;
        int x;
        int y;
        int w;
        int h;
        int idx;
        bit stop;
        v[0] = p.red_in;
        v[1] = p.green_in;
        v[2] = p.blue_in;
        v[3] = p.alpha_in;
        stop = 0;
        for (int l = 0; l < num_levels && !stop; l++)
        begin
            x = col_pos[l];
            y = row_pos[l];
            w = level_w[l];
            h = level_h[l];
            r = '0;
            r.mip_level = bfmc_pkg::LvlW'(l);
            r.pixel_x = bfmc_pkg::PosW'(x);
            r.pixel_y = bfmc_pkg::PosW'(y);
            r.red_out = v[0];
            r.green_out = v[1];
            r.blue_out = v[2];
            r.alpha_out = v[3];
            expected_pixels = {expected_pixels, r};
            col_pos[l] = x + 1;
            if (col_pos[l] >= w)
            begin
                col_pos[l] = 0;
                row_pos[l] = (y + 1 >= h) ? 0 : y + 1;
            end
            if (l + 1 >= num_levels)
                stop = 1;
            else if (w != 1 && x % 2 == 0)
            begin
                for (int c = 0; c < 4; c++)
                    left_hold[l][c] = v[c];
                stop = 1;
            end
            else
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a = v[c];
                    b = (w == 1) ? v[c] : left_hold[l][c];
                    pair[c] = a + b;
                end
                idx = level_off[l] + x / 2;
                if (idx >= bfmc_pkg::MaxDim)
                    stop = 1;
                else if (h != 1 && y % 2 == 0)
                begin
                    for (int c = 0; c < 4; c++)
                        row_pair_sums[c][idx] = pair[c];
                    stop = 1;
                end
                else
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        total = (h == 1) ? pair[c] : row_pair_sums[c][idx];
                        total = total + pair[c];
                        v[c] = total[33:2];
                    end
                end
            end
        end
        expected_pixels[expected_pixels.size() - 1].last_of_run = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bfmc_pkg::pix_out_t want;
        if (!rst_n)
        begin
            width_reg = 1;
            height_reg = 1;
            rebuild_levels();
            expected_pixels.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bfmc_pkg::REG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                rebuild_levels();
            end
            if (in_valid && !in_stall)
                predict_pixels(in_data);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected output pixel %p", $realtime, out_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: pixel mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, out_data);
                    end
                end
            end
        end
    end

endmodule

### verif/box_filter_mip_chain_unit_test.sv
// Top of the box filter mip chain unit test: clock, reset, config writes,
// pixel stimulus, output stalls and verdict. Depends on bfmc_pkg and the checker.
`timescale 1ns / 1ps
module box_filter_mip_chain_unit_test;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    bfmc_pkg::pix_in_t  in_data;
    logic               out_valid;
    logic               out_stall;
    bfmc_pkg::pix_out_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [0:0]         cfg_index;
    logic [12:0]        cfg_data;

    int fail_count;
    int pending;
    int results_seen;

    // Idle controls, set per phase by the stimulus process.
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  pressure_go;
    bit  pressure_done;
    int  hold_left;
    int  pixels_sent;
    int  phases_run;

    box_filter_mip_chain_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_filter_mip_chain_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off when the stimulus
    // asks for it so the unit backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            pressure_done = 0;
        end
        else
        begin
            if (pressure_go && !pressure_done)
            begin
                hold_left = 300;
                pressure_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Pick a channel value, leaning on the extremes.
    function automatic logic [31:0] pick_channel();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'($urandom_range(0, 255)) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request; hold it until accepted.
    task automatic send_pixel(bfmc_pkg::pix_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then settle long enough for the deepest level to finish.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // One phase: set the image size, then stream pixels. Extreme mode cycles
    // each channel through max, min, zero and minus one.
    task automatic run_phase(int w, int h, int count, int mode, bit extreme);
        logic [31:0] table_vals [4];
        bfmc_pkg::pix_in_t p;
        table_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
        wait_drained();
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        write_reg(bfmc_pkg::REG_WIDTH, 13'(w));
        write_reg(bfmc_pkg::REG_HEIGHT, 13'(h));
        phases_run++;
        for (int i = 0; i < count; i++)
        begin
            if (extreme)
            begin
                p.red_in   = table_vals[i % 4];
                p.green_in = table_vals[(i + 1) % 4];
                p.blue_in  = table_vals[(i + 2) % 4];
                p.alpha_in = table_vals[(i + 3) % 4];
            end
            else
            begin
                p.red_in   = pick_channel();
                p.green_in = pick_channel();
                p.blue_in  = pick_channel();
                p.alpha_in = pick_channel();
            end
            send_pixel(p);
        end
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int random_total;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pressure_go = 0;
        pixels_sent = 0;
        phases_run = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 1x1 echo, zero and oversize dimensions, odd sizes,
        // negative floor in the 2x2 average, wrap into a second image.
        run_phase(1, 1, 2, 0, 1);
        run_phase(0, 0, 2, 1, 1);
        run_phase(2, 2, 8, 2, 1);
        run_phase(3, 1, 3, 3, 1);
        run_phase(1, 3, 3, 0, 0);
        run_phase(8191, 2, 5, 2, 0);
        run_phase(2, 4096, 2, 1, 0);
        run_phase(4096, 4096, 2, 0, 0);

        // Long output hold-off on two full 6x6 images.
        wait_drained();
        pressure_go = 1;
        run_phase(6, 6, 72, 0, 0);

        // Random images: mostly small, whole images, some cut short.
        random_total = 0;
        while (random_total < 300)
        begin
            w = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 9);
            h = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 9);
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, n);
            run_phase(w, h, n, phases_run, 0);
            random_total += n;
        end

        wait_drained();
        $display("Covered %0d pixels over %0d image sizes, %0d output pixels checked.",
                 pixels_sent, phases_run, results_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
